// ===== hw/rtl/kbe_pkg.sv =====
// Package with field widths, opcodes and parameter defaults for the k-mer bit-plane extractor.
`timescale 1ns / 1ps
`default_nettype none

package kbe_pkg;

  // Field widths of one input transaction.
  localparam int ADDR_W = 10;
  localparam int WORD_W = 64;
  localparam int POS_W  = 15;
  localparam int LEN_W  = 7;

  // Width of the base count register.
  localparam int BC_W = 16;

  // Bases per block are 2**OFF_W, one bit per base in each plane word.
  localparam int OFF_W = 6;
  localparam int BLK_W = POS_W - OFF_W;

  // Packed stream widths.
  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 2 * WORD_W;

  // Parameter defaults.
  localparam int KMER_CAPACITY_DEF = 64;
  localparam int SEQ_BLOCKS_DEF    = 512;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_EXTRACT = 1'b1
  } opcode_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kmer_bitplane_extractor.sv =====
// K-mer bit-plane extractor: banked two-plane sequence store and three-stage gather pipeline.
`timescale 1ns / 1ps
`default_nettype none

// The block stores a DNA sequence as two bit planes, 64 bases per block, with
// base 0 of each block at the most significant bit of its words. A write
// transaction (tuser low) stores one 64-bit plane word at word address
// block*2 + plane; a write at or above 2*SEQ_BLOCKS is dropped and a write
// never produces a result. An extract transaction (tuser high) returns the
// kmer_length bases starting at start_position from both planes, left-aligned
// at bit KMER_CAPACITY-1 with every other bit zero. If the length exceeds
// KMER_CAPACITY or start plus length exceeds base_count, the result carries
// range_error set and both planes zero. Blocks at or beyond SEQ_BLOCKS read
// as zero. The store has no reset and no clearing pass: an extract that
// touches a word never written returns undefined bits for that word. The
// block accepts one transaction every cycle while s_tready is high; the
// result of an extract passes three register stages (store read, funnel
// shift, mask), and m_tvalid is the valid flag of the mask stage. This rate
// comes from splitting the store into an even-block bank and an odd-block
// bank per plane, so the two blocks a k-mer may straddle are always read
// in the same cycle from different banks. Each stage holds its data while
// the one after it is full and cannot pass its data on, so back-pressure on
// the master side stalls the pipeline without loss or repetition, and the
// slave side stays ready as long as any stage has room.
// base_count must be written only while no extract is in flight.

module kmer_bitplane_extractor
  import kbe_pkg::*;
#(
  parameter int KMER_CAPACITY = KMER_CAPACITY_DEF,
  parameter int SEQ_BLOCKS    = SEQ_BLOCKS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [BC_W-1:0]      cfg_data,      // base_count

  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [9:0] word_address, [73:10] word_data, [88:74] start_position, [95:89] kmer_length
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  input  wire logic                 s_tuser,       // [0] opcode

  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,       // [63:0] first_plane, [127:64] second_plane
  output logic                      m_tuser        // [0] range_error
);

  // Each bank holds every other block; an odd block count rounds the even bank up.
  localparam int BANK_DEPTH = (SEQ_BLOCKS + 1) / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CAP_SHIFT  = WORD_W - KMER_CAPACITY;

  // Configuration register. Writes are always taken.
  logic [BC_W-1:0] base_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      base_count <= cfg_data;
    end
  end

  // Unpack the slave transaction.
  opcode_t            in_op;
  logic [ADDR_W-1:0]  in_addr;
  logic [WORD_W-1:0]  in_word;
  logic [POS_W-1:0]   in_pos;
  logic [LEN_W-1:0]   in_len;

  assign in_op   = opcode_t'(s_tuser);
  assign in_addr = s_tdata[ADDR_W-1:0];
  assign in_word = s_tdata[ADDR_W +: WORD_W];
  assign in_pos  = s_tdata[ADDR_W + WORD_W +: POS_W];
  assign in_len  = s_tdata[ADDR_W + WORD_W + POS_W +: LEN_W];

  // Pipeline handshake: a stage loads when it is empty or its successor loads.
  logic v1, v2;
  logic en1, en2, en3;
  logic s_accept;

  assign en3      = !m_tvalid || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign s_accept = s_tvalid && s_tready;

  // Store write decode. Address bit 0 picks the plane, bit 1 the bank.
  logic [ADDR_W-2:0] wr_block;
  logic              wr_en;
  logic [BANK_AW-1:0] wr_row;

  assign wr_block = in_addr[ADDR_W-1:1];
  assign wr_en    = s_accept && (in_op == OP_WRITE) && (32'(wr_block) < SEQ_BLOCKS);
  assign wr_row   = BANK_AW'(in_addr[ADDR_W-1:2]);

  // Read decode. The first block and the one after it always fall in opposite
  // banks; the even bank reads the even one of the two.
  logic [BLK_W-1:0]   rd_block;
  logic [BLK_W:0]     rd_next;
  logic [BLK_W:0]     even_sum;
  logic [BANK_AW-1:0] even_row;
  logic [BANK_AW-1:0] odd_row;
  logic [BC_W-1:0]    end_pos;
  logic               in_err;

  assign rd_block = in_pos[POS_W-1:OFF_W];
  assign rd_next  = (BLK_W + 1)'(rd_block) + 1'b1;
  assign even_sum = (BLK_W + 1)'(rd_block) + (BLK_W + 1)'(rd_block[0]);
  assign even_row = BANK_AW'(even_sum[BLK_W:1]);
  assign odd_row  = BANK_AW'(rd_block[BLK_W-1:1]);

  assign end_pos = BC_W'(in_pos) + BC_W'(in_len);
  assign in_err  = (32'(in_len) > KMER_CAPACITY) || (end_pos > base_count);

  // Four banks: even/odd block by plane 0/1. Read data registers form stage 1.
  logic [WORD_W-1:0] mem_e0 [BANK_DEPTH];
  logic [WORD_W-1:0] mem_e1 [BANK_DEPTH];
  logic [WORD_W-1:0] mem_o0 [BANK_DEPTH];
  logic [WORD_W-1:0] mem_o1 [BANK_DEPTH];
  logic [WORD_W-1:0] rd_e0, rd_e1, rd_o0, rd_o1;

  always_ff @(posedge clk) begin
    if (wr_en && !in_addr[1] && !in_addr[0]) begin
      mem_e0[wr_row] <= in_word;
    end
    if (en1) begin
      rd_e0 <= mem_e0[even_row];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !in_addr[1] && in_addr[0]) begin
      mem_e1[wr_row] <= in_word;
    end
    if (en1) begin
      rd_e1 <= mem_e1[even_row];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && in_addr[1] && !in_addr[0]) begin
      mem_o0[wr_row] <= in_word;
    end
    if (en1) begin
      rd_o0 <= mem_o0[odd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && in_addr[1] && in_addr[0]) begin
      mem_o1[wr_row] <= in_word;
    end
    if (en1) begin
      rd_o1 <= mem_o1[odd_row];
    end
  end

  // Stage 1 control, alongside the read data.
  logic             err1;
  logic             swap1;    // first block is odd, so it sits in the odd bank
  logic             hib1;     // first block lies beyond the store
  logic             lob1;     // next block lies beyond the store
  logic [OFF_W-1:0] off1;
  logic [LEN_W-1:0] len1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid && (in_op == OP_EXTRACT);
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      err1  <= in_err;
      swap1 <= rd_block[0];
      hib1  <= 32'(rd_block) >= SEQ_BLOCKS;
      lob1  <= 32'(rd_next) >= SEQ_BLOCKS;
      off1  <= in_pos[OFF_W-1:0];
      len1  <= in_len;
    end
  end

  // Stage 2: pick first and next block words per plane and funnel-shift by the offset.
  logic [WORD_W-1:0]   hi0, hi1, lo0, lo1;
  logic [2*WORD_W-1:0] fun0, fun1;
  logic [WORD_W-1:0]   g0, g1;
  logic                err2;
  logic [LEN_W-1:0]    len2;

  always_comb begin
    hi0 = swap1 ? rd_o0 : rd_e0;
    hi1 = swap1 ? rd_o1 : rd_e1;
    lo0 = swap1 ? rd_e0 : rd_o0;
    lo1 = swap1 ? rd_e1 : rd_o1;
    if (hib1) begin
      hi0 = '0;
      hi1 = '0;
    end
    if (lob1) begin
      lo0 = '0;
      lo1 = '0;
    end
    fun0 = {hi0, lo0} << off1;
    fun1 = {hi1, lo1} << off1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      g0   <= fun0[2*WORD_W-1:WORD_W];
      g1   <= fun1[2*WORD_W-1:WORD_W];
      err2 <= err1;
      len2 <= len1;
    end
  end

  // Stage 3: keep the top len bits, clear everything on error, align to the capacity.
  logic [WORD_W-1:0] len_mask;
  logic [WORD_W-1:0] p0_next, p1_next;

  always_comb begin
    len_mask = ~({WORD_W{1'b1}} >> len2);
    p0_next  = err2 ? '0 : ((g0 & len_mask) >> CAP_SHIFT);
    p1_next  = err2 ? '0 : ((g1 & len_mask) >> CAP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en3) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      m_tdata <= {p1_next, p0_next};
      m_tuser <= err2;
    end
  end

  // A write transaction never enters the result pipeline.
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_accept && in_op == OP_WRITE) |=> !v1)
    else $error("write transaction entered the result pipeline");

  // Every accepted extract occupies stage 1 on the next cycle.
  a_extract_enters: assert property (@(posedge clk) disable iff (rst)
    (s_accept && in_op == OP_EXTRACT) |=> v1)
    else $error("accepted extract transaction was lost");

  // The slave side only stalls when every stage is full and the output is held.
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && m_tvalid && !m_tready))
    else $error("slave side stalled with room in the pipeline");

  // A rejected request carries zero planes.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("range error result carries nonzero plane bits");

endmodule

`default_nettype wire
